// ===== rtl/core/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros for the deframer rtl
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, disabled while in reset
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/core/sfd_pkg.sv =====
// ----------------------------------------------------------------------------
// sfd_pkg
// shared types, result codes and crc helpers for the stuffed frame deframer
// ----------------------------------------------------------------------------
`default_nettype none

package sfd_pkg;

    // result kinds
    localparam logic [1:0] KIND_DATA  = 2'd0;
    localparam logic [1:0] KIND_GOOD  = 2'd1;
    localparam logic [1:0] KIND_BAD   = 2'd2;
    localparam logic [1:0] KIND_ABORT = 2'd3;

    // configuration register indexes
    localparam int         CFG_AW        = 2;
    localparam logic [1:0] CFG_START     = 2'd0;
    localparam logic [1:0] CFG_END       = 2'd1;
    localparam logic [1:0] CFG_ESCAPE    = 2'd2;

    // mark reset values
    localparam logic [7:0] START_RST  = 8'h02;
    localparam logic [7:0] END_RST    = 8'h03;
    localparam logic [7:0] ESCAPE_RST = 8'h10;

    // field widths
    localparam int LEN_W = 9;

    // output queue sizing
    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_PW    = $clog2(FIFO_DEPTH);
    localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

    // one result word
    typedef struct packed {
        logic [1:0]       kind;
        logic [7:0]       data;
        logic [LEN_W-1:0] len;
        logic             last;
    } result_t;

    // up to two results caused by one input word
    typedef struct packed {
        logic [1:0] n;
        result_t    r0;
        result_t    r1;
    } res_pair_t;

    // reflected poly 0x8408, one nibble per entry
    localparam logic [15:0] NIB_TAB [16] = '{
        16'h0000, 16'h1081, 16'h2102, 16'h3183, 16'h4204, 16'h5285, 16'h6306, 16'h7387,
        16'h8408, 16'h9489, 16'ha50a, 16'hb58b, 16'hc60c, 16'hd68d, 16'he70e, 16'hf78f
    };

    // fold one byte into the crc, low nibble first
    function automatic logic [15:0] crc_fold(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] t;
        t = {4'h0, crc[15:4]} ^ NIB_TAB[crc[3:0] ^ b[3:0]];
        t = {4'h0, t[15:4]} ^ NIB_TAB[t[3:0] ^ b[7:4]];
        return t;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/core/stuffed_frame_deframer_crc16.sv =====
// ----------------------------------------------------------------------------
// stuffed_frame_deframer_crc16
// byte-stuffed frame receiver with crc-16 (reflected 0x8408) frame check
// ----------------------------------------------------------------------------
// One raw byte per cycle is taken on the slave side whenever the output queue
// has room for two results; with the master side always ready this sustains
// one word per cycle, and a byte that unstuffs to two results adds an extra
// output word. A result is registered in a four-entry result queue that also
// decouples input from output stalls. Each result carries the payload byte in
// tdata or a frame status (good, checksum error, overflow abort) in tuser, and
// tlast marks the last result of a byte.
`default_nettype none

module stuffed_frame_deframer_crc16 #(
    parameter int MAX_FRAME = 256
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    // configuration
    input  wire logic                       cfg_we,
    input  wire logic [sfd_pkg::CFG_AW-1:0] cfg_addr,
    input  wire logic [7:0]                 cfg_wdata,
    // raw serial bytes
    input  wire logic                       s_tvalid,
    output logic                            s_tready,
    input  wire logic [7:0]                 s_tdata,   // in_byte[7:0]
    // unstuffed results
    output logic                            m_tvalid,
    input  wire logic                       m_tready,
    output logic [23:0]                     m_tdata,   // data_byte[7:0], frame_length[16:8]
    output logic [1:0]                      m_tuser,   // kind[1:0]
    output logic                            m_tlast
);
    import sfd_pkg::*;

    logic      accept;
    res_pair_t pair;
    result_t   head;

    assign accept = s_tvalid && s_tready;

    // unstuffing and crc
    sfd_unstuff #(
        .MAX_FRAME (MAX_FRAME)
    ) u_unstuff (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_valid  (accept),
        .in_byte   (s_tdata),
        .res       (pair)
    );

    // result queue
    sfd_out_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (pair),
        .room      (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_res   (head)
    );

    // output word packing
    assign m_tdata = {7'b0, head.len, head.data};
    assign m_tuser = head.kind;
    assign m_tlast = head.last;

endmodule

`default_nettype wire

// ===== rtl/core/sfd_unstuff.sv =====
// ----------------------------------------------------------------------------
// sfd_unstuff
// mark registers, frame state, unstuffing and crc check for one input word
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_unstuff #(
    parameter int MAX_FRAME = 256
) (
    input  wire logic                      clk,
    input  wire logic                      rst_n,
    input  wire logic                      cfg_we,
    input  wire logic [sfd_pkg::CFG_AW-1:0] cfg_addr,
    input  wire logic [7:0]                cfg_wdata,
    input  wire logic                      in_valid,
    input  wire logic [7:0]                in_byte,
    output sfd_pkg::res_pair_t             res
);
    import sfd_pkg::*;
    `include "assert_macros.svh"

    localparam int             CNT_W   = $clog2(MAX_FRAME + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FRAME);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    localparam logic [1:0] MODE_IDLE = 2'd0;
    localparam logic [1:0] MODE_READ = 2'd1;
    localparam logic [1:0] MODE_ESC  = 2'd2;

    logic [7:0]       start_reg, end_reg, escape_reg;
    logic [1:0]       mode_reg, mode_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [15:0]      crc_reg, crc_next;

    logic             a_en, abort_a, b_en, abort_b;
    logic [CNT_W-1:0] cnt_a, cnt_b;
    logic [15:0]      crc_a, crc_b;
    result_t          res_a, res_b;
    res_pair_t        pair;

    function automatic logic [LEN_W-1:0] len_of(input logic [CNT_W-1:0] v);
        logic [CNT_W+LEN_W-1:0] w;
        w = {{LEN_W{1'b0}}, v};
        return w[LEN_W-1:0];
    endfunction

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start_reg  <= START_RST;
            end_reg    <= END_RST;
            escape_reg <= ESCAPE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                CFG_START:  start_reg  <= cfg_wdata;
                CFG_END:    end_reg    <= cfg_wdata;
                CFG_ESCAPE: escape_reg <= cfg_wdata;
                default:    ;
            endcase
        end
    end

    // first store: the held escape byte after an escape
    always_comb
    begin
        a_en    = (mode_reg == MODE_ESC) && (in_byte != start_reg) && (in_byte != end_reg);
        abort_a = a_en && (count_reg >= MAX_CNT);
        cnt_a   = (a_en && !abort_a) ? count_reg + CNT_ONE : count_reg;
        crc_a   = (a_en && !abort_a) ? crc_fold(crc_reg, escape_reg) : crc_reg;
        res_a.kind = abort_a ? KIND_ABORT : KIND_DATA;
        res_a.data = abort_a ? 8'h00 : escape_reg;
        res_a.len  = len_of(cnt_a);
        res_a.last = 1'b0;
    end

    // second store: the received word itself
    always_comb
    begin
        b_en    = ((mode_reg == MODE_ESC) && !abort_a && (in_byte != escape_reg)) ||
                  ((mode_reg == MODE_READ) && (in_byte != escape_reg) &&
                   (in_byte != end_reg));
        abort_b = b_en && (cnt_a >= MAX_CNT);
        cnt_b   = (b_en && !abort_b) ? cnt_a + CNT_ONE : cnt_a;
        crc_b   = (b_en && !abort_b) ? crc_fold(crc_a, in_byte) : crc_a;
        res_b.kind = abort_b ? KIND_ABORT : KIND_DATA;
        res_b.data = abort_b ? 8'h00 : in_byte;
        res_b.len  = len_of(cnt_b);
        res_b.last = 1'b0;
    end

    // next state and result selection
    always_comb
    begin
        mode_next  = mode_reg;
        count_next = cnt_b;
        crc_next   = crc_b;
        pair       = '0;
        unique case (mode_reg)
            MODE_READ:
            begin
                if (in_byte == escape_reg)
                begin
                    mode_next = MODE_ESC;
                end
                else if (in_byte == end_reg)
                begin
                    pair.n       = 2'd1;
                    pair.r0.kind = (crc_reg == 16'h0000) ? KIND_GOOD : KIND_BAD;
                    pair.r0.len  = len_of(count_reg);
                    mode_next    = MODE_IDLE;
                end
                else
                begin
                    pair.n    = 2'd1;
                    pair.r0   = res_b;
                    mode_next = abort_b ? MODE_IDLE : MODE_READ;
                end
            end
            MODE_ESC:
            begin
                pair.n    = {1'b0, a_en} + {1'b0, b_en};
                pair.r0   = a_en ? res_a : res_b;
                pair.r1   = res_b;
                mode_next = (abort_a || abort_b) ? MODE_IDLE : MODE_READ;
            end
            default:
            begin
                mode_next = MODE_IDLE;
                if (in_byte == start_reg)
                begin
                    mode_next  = MODE_READ;
                    count_next = '0;
                    crc_next   = 16'h0000;
                end
            end
        endcase

        // mark the final result of this word
        if (pair.n == 2'd1)
            pair.r0.last = 1'b1;
        if (pair.n == 2'd2)
            pair.r1.last = 1'b1;
        if (!in_valid)
            pair.n = 2'd0;
    end

    assign res = pair;

    // frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg  <= MODE_IDLE;
            count_reg <= '0;
            crc_reg   <= 16'h0000;
        end
        else if (in_valid)
        begin
            mode_reg  <= mode_next;
            count_reg <= count_next;
            crc_reg   <= crc_next;
        end
    end

    // checks
    `ASSERT_IMP(a_two_only_esc, clk, rst_n, pair.n == 2'd2, mode_reg == MODE_ESC,
                "two results outside escape mode")
    `ASSERT_NEXT(a_abort_idle, clk, rst_n, in_valid && (abort_a || abort_b),
                 mode_reg == MODE_IDLE, "abort did not return to idle")
    `ASSERT_IMP(a_count_max, clk, rst_n, 1'b1, count_reg <= MAX_CNT,
                "byte count beyond maximum frame")

endmodule

`default_nettype wire

// ===== rtl/core/sfd_out_queue.sv =====
// ----------------------------------------------------------------------------
// sfd_out_queue
// small result queue: takes up to two results per cycle, gives one
// ----------------------------------------------------------------------------
`default_nettype none

module sfd_out_queue (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire sfd_pkg::res_pair_t push,
    output logic                    room,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output sfd_pkg::result_t        out_res
);
    import sfd_pkg::*;
    `include "assert_macros.svh"

    localparam logic [FIFO_PW-1:0] PTR_ONE = FIFO_PW'(1);
    localparam logic [FIFO_CW-1:0] ROOM_MAX = FIFO_CW'(FIFO_DEPTH - 2);

    result_t            entry_reg [FIFO_DEPTH];
    logic [FIFO_PW-1:0] wr_ptr_reg, wr_ptr_next;
    logic [FIFO_PW-1:0] rd_ptr_reg, rd_ptr_next;
    logic [FIFO_CW-1:0] count_reg, count_next;
    logic               pop;

    assign room      = (count_reg <= ROOM_MAX);
    assign out_valid = (count_reg != '0);
    assign out_res   = entry_reg[rd_ptr_reg];
    assign pop       = out_valid && out_ready;

    // pointer and level update
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg + FIFO_PW'(push.n);
        rd_ptr_next = pop ? rd_ptr_reg + PTR_ONE : rd_ptr_reg;
        count_next  = count_reg + FIFO_CW'(push.n) - FIFO_CW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // result storage
    always_ff @(posedge clk)
    begin
        if (push.n != 2'd0)
            entry_reg[wr_ptr_reg] <= push.r0;
        if (push.n == 2'd2)
            entry_reg[wr_ptr_reg + PTR_ONE] <= push.r1;
    end

    // checks
    `ASSERT_IMP(a_level, clk, rst_n, 1'b1, count_reg <= FIFO_CW'(FIFO_DEPTH),
                "queue level beyond depth")
    `ASSERT_IMP(a_push_room, clk, rst_n, push.n != 2'd0, room,
                "results pushed without room for two")

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the byte-stuffed frame deframer with CRC-16 check.
// A behavioral deframer inside the bench tracks mode, byte count, CRC and the
// mark registers. It builds the expected result words for every raw byte that
// the block accepts. A monitor compares each result word field by field. Both
// stream sides idle at random, with one long output stall and steady
// stretches. Frames are mostly well formed under several mark settings;
// noise, truncated frames, bad checksums and overflowing frames are mixed in.
// ----------------------------------------------------------------------------
`default_nettype none

module tb;

    import sfd_pkg::*;

    localparam int MAX_FRAME = 256;

    typedef enum logic [1:0] {RX_IDLE, RX_READ, RX_ESC} rx_state_t;

    logic                clk;
    logic                rst_n;
    logic                cfg_we;
    logic [CFG_AW-1:0]   cfg_addr;
    logic [7:0]          cfg_wdata;
    logic                s_tvalid;
    logic                s_tready;
    logic [7:0]          s_tdata;    // in_byte[7:0]
    logic                m_tvalid;
    logic                m_tready;
    logic [23:0]         m_tdata;    // data_byte[7:0], frame_length[16:8]
    logic [1:0]          m_tuser;    // kind[1:0]
    logic                m_tlast;

    // deframer state as the bench sees it
    rx_state_t   rx_state;
    int          frame_cnt;
    logic [15:0] frame_crc;
    logic [7:0]  mark_start;
    logic [7:0]  mark_end;
    logic [7:0]  mark_esc;
    int          step_n;

    result_t     expected_words[$];
    logic [7:0]  frame_body[$];

    bit          tx_steady;
    bit          rx_steady;
    bit          hold_req;
    int          words_in;
    int          words_out;
    int          mismatches;
    int          frames_good;
    int          frames_bad;
    int          frames_aborted;

    stuffed_frame_deframer_crc16 #(
        .MAX_FRAME (MAX_FRAME)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .m_tlast   (m_tlast)
    );

    // clock
    initial clk = 1'b0;
    always #5 clk = ~clk;

    // run limit
    initial
    begin
        #(5_000_000);
        $display("status: fail");
        $finish;
    end

    // reflected crc-16, poly 0x8408, one bit at a time, lsb first
    function automatic logic [15:0] crc_update(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        int          i;
        c = crc;
        for (i = 0; i < 8; i++)
            c = (c[0] ^ b[i]) ? ((c >> 1) ^ 16'h8408) : (c >> 1);
        return c;
    endfunction

    // queue one expected result word at the current frame count
    task automatic push_word(input logic [1:0] k, input logic [7:0] d);
        result_t w;
        w.kind = k;
        w.data = d;
        w.len  = frame_cnt[LEN_W-1:0];
        w.last = 1'b0;
        expected_words = {expected_words, w};
        step_n++;
    endtask

    // store one payload byte, or abort when the frame is already full
    task automatic store_payload(input logic [7:0] b, output bit ok);
        if (frame_cnt >= MAX_FRAME)
        begin
            push_word(KIND_ABORT, 8'h00);
            rx_state = RX_IDLE;
            ok = 1'b0;
        end
        else
        begin
            frame_cnt++;
            frame_crc = crc_update(frame_crc, b);
            push_word(KIND_DATA, b);
            ok = 1'b1;
        end
    endtask

    // expected results for one accepted raw byte
    task automatic deframe_byte(input logic [7:0] c);
        bit      ok;
        result_t w;
        step_n = 0;
        case (rx_state)
            RX_READ:
            begin
                // escape is tested before the end mark
                if (c == mark_esc)
                    rx_state = RX_ESC;
                else if (c == mark_end)
                begin
                    push_word((frame_crc == 16'h0000) ? KIND_GOOD : KIND_BAD, 8'h00);
                    rx_state = RX_IDLE;
                end
                else
                    store_payload(c, ok);
            end
            RX_ESC:
            begin
                // marks after an escape are literal; escape pair gives one escape
                ok = 1'b1;
                rx_state = RX_READ;
                if (c != mark_start && c != mark_end)
                    store_payload(mark_esc, ok);
                if (ok && c != mark_esc)
                    store_payload(c, ok);
            end
            default:
            begin
                if (c == mark_start)
                begin
                    rx_state  = RX_READ;
                    frame_cnt = 0;
                    frame_crc = 16'h0000;
                end
            end
        endcase
        if (step_n > 0)
        begin
            w = expected_words.pop_back();
            w.last = 1'b1;
            expected_words = {expected_words, w};
        end
    endtask

    // one raw byte on the input side, with random idle cycles ahead of it
    task automatic send_byte(input logic [7:0] b);
        if (!tx_steady)
        begin
            while ($urandom_range(0, 99) < 26)
            begin
                s_tvalid <= 1'b0;
                @(posedge clk);
            end
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        deframe_byte(b);
        words_in++;
    endtask

    // payload byte, escaped when it equals a mark
    task automatic send_stuffed(input logic [7:0] b);
        if (b == mark_start || b == mark_end || b == mark_esc)
            send_byte(mark_esc);
        send_byte(b);
    endtask

    task automatic send_raw();
        foreach (frame_body[i])
            send_byte(frame_body[i]);
    endtask

    // start mark, stuffed body, crc low then high, optional end mark
    task automatic send_frame(input bit crc_ok, input bit closed);
        logic [15:0] crc;
        crc = 16'h0000;
        foreach (frame_body[i])
            crc = crc_update(crc, frame_body[i]);
        if (!crc_ok)
            crc = crc ^ (16'h0001 << $urandom_range(0, 15));
        send_byte(mark_start);
        foreach (frame_body[i])
            send_stuffed(frame_body[i]);
        send_stuffed(crc[7:0]);
        send_stuffed(crc[15:8]);
        if (closed)
            send_byte(mark_end);
    endtask

    task automatic fill_body(input int len);
        frame_body.delete();
        repeat (len)
            frame_body = {frame_body, 8'($urandom_range(0, 255))};
    endtask

    // open a frame and fill it with bytes that match none of the reset marks
    task automatic open_plain(input int len);
        send_byte(mark_start);
        repeat (len)
            send_byte(8'($urandom_range(8'h20, 8'h7f)));
    endtask

    // stop sending and let every expected word come out
    task automatic wait_results_done();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (expected_words.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // write all three mark registers on consecutive cycles
    task automatic set_marks(input logic [7:0] st, input logic [7:0] en, input logic [7:0] es);
        cfg_we    <= 1'b1;
        cfg_addr  <= CFG_START;
        cfg_wdata <= st;
        @(posedge clk);
        cfg_addr  <= CFG_END;
        cfg_wdata <= en;
        @(posedge clk);
        cfg_addr  <= CFG_ESCAPE;
        cfg_wdata <= es;
        @(posedge clk);
        cfg_we    <= 1'b0;
        mark_start = st;
        mark_end   = en;
        mark_esc   = es;
    endtask

    task automatic report_mismatch(input string field, input logic [15:0] want,
                                   input logic [15:0] got);
        mismatches++;
        $display("mismatch %s: want %0h got %0h at %0t", field, want, got, $realtime);
    endtask

    // output side: random stalls, steady stretches and one long hold-off
    initial
    begin
        m_tready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                m_tready <= 1'b0;
                repeat (150) @(posedge clk);
                hold_req = 1'b0;
            end
            else if (rx_steady)
                m_tready <= 1'b1;
            else
                m_tready <= ($urandom_range(0, 99) >= 26);
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        result_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            words_out++;
            if (expected_words.size() == 0)
                report_mismatch("unexpected word, kind", 16'h0, 16'(m_tuser));
            else
            begin
                want = expected_words.pop_front();
                if (m_tuser !== want.kind)
                    report_mismatch("kind", 16'(want.kind), 16'(m_tuser));
                if (m_tdata[7:0] !== want.data)
                    report_mismatch("data_byte", 16'(want.data), 16'(m_tdata[7:0]));
                if (m_tdata[16:8] !== want.len)
                    report_mismatch("frame_length", 16'(want.len), 16'(m_tdata[16:8]));
                if (m_tlast !== want.last)
                    report_mismatch("last", 16'(want.last), 16'(m_tlast));
                if (want.kind == KIND_GOOD)
                    frames_good++;
                else if (want.kind == KIND_BAD)
                    frames_bad++;
                else if (want.kind == KIND_ABORT)
                    frames_aborted++;
            end
        end
    end

    // reset marks: idle noise, empty frame, escapes, checksum good and bad
    task automatic test_directed();
        set_marks(START_RST, END_RST, ESCAPE_RST);
        // end and escape marks outside a frame are ignored
        frame_body = '{8'h00, 8'hff, END_RST, ESCAPE_RST};
        send_raw();
        // empty frame closes good with length zero
        frame_body = '{START_RST, END_RST};
        send_raw();
        // raw start inside a frame, escaped start, end, escape, escape + other
        frame_body = '{START_RST, 8'h41, START_RST, ESCAPE_RST, START_RST, ESCAPE_RST,
                       END_RST, ESCAPE_RST, ESCAPE_RST, ESCAPE_RST, 8'hff, END_RST};
        send_raw();
        frame_body = '{8'h00, 8'hff};
        send_frame(1'b1, 1'b1);
        frame_body = '{ESCAPE_RST};
        send_frame(1'b0, 1'b1);
        wait_results_done();
    endtask

    // extreme and coinciding mark values
    task automatic test_marks();
        set_marks(8'h00, 8'hff, 8'h80);
        frame_body = '{8'h00, 8'hff, 8'h80, 8'h7f};
        send_frame(1'b1, 1'b1);
        wait_results_done();
        set_marks(8'hff, 8'h00, 8'h7f);
        frame_body = '{8'h00, 8'hff, 8'h7f, 8'h80};
        send_frame(1'b1, 1'b1);
        wait_results_done();
        // start equals escape: escaped start stores nothing
        set_marks(8'h5a, 8'h3c, 8'h5a);
        frame_body = '{8'h5a, 8'h41, 8'h5a, 8'h3c, 8'h5a, 8'h5a, 8'h5a, 8'h42, 8'h3c};
        send_raw();
        wait_results_done();
        // end equals escape: the frame stays open
        set_marks(8'h55, 8'haa, 8'haa);
        frame_body = '{8'h55, 8'h41, 8'haa, 8'haa, 8'haa, 8'h42, 8'h55};
        send_raw();
        wait_results_done();
        // all marks equal, still inside the open frame
        set_marks(8'h00, 8'h00, 8'h00);
        frame_body = '{8'h00, 8'h00, 8'h41, 8'h00, 8'h41};
        send_raw();
        wait_results_done();
        // distinct end mark finally closes it
        set_marks(8'h01, 8'h00, 8'h02);
        send_byte(8'h00);
        wait_results_done();
        set_marks(START_RST, END_RST, ESCAPE_RST);
    endtask

    // the abort paths at the length limit
    task automatic test_overflow();
        // escaped start fills the last slot, the next byte aborts, end falls into idle
        open_plain(MAX_FRAME - 1);
        send_byte(mark_esc);
        send_byte(mark_start);
        send_byte(8'h41);
        send_byte(mark_end);
        // escape + other with one slot left: escape stored, byte aborts
        open_plain(MAX_FRAME - 1);
        send_byte(mark_esc);
        send_byte(8'h41);
        // escape pair on a full frame aborts at the escape byte
        open_plain(MAX_FRAME);
        send_byte(mark_esc);
        send_byte(mark_esc);
        wait_results_done();
    endtask

    // long output stall, then a sender pause in the middle of a frame
    task automatic test_backpressure();
        hold_req = 1'b1;
        fill_body(24);
        send_frame(1'b1, 1'b1);
        send_byte(mark_start);
        repeat (6)
            send_stuffed(8'($urandom_range(0, 255)));
        wait_results_done();
        repeat (6)
            send_stuffed(8'($urandom_range(0, 255)));
        send_byte(mark_end);
        wait_results_done();
    endtask

    // random frames, noise and broken sequences under several mark settings
    task automatic test_random();
        int         phase;
        int         base;
        int         pick;
        int         len;
        logic [7:0] st;
        logic [7:0] en;
        logic [7:0] es;
        for (phase = 0; phase < 6; phase++)
        begin
            if (phase == 0)
                set_marks(START_RST, END_RST, ESCAPE_RST);
            else if (phase == 1)
                set_marks(8'hff, 8'h00, 8'h80);
            else
            begin
                st = 8'($urandom_range(0, 255));
                do en = 8'($urandom_range(0, 255)); while (en == st);
                do es = 8'($urandom_range(0, 255)); while (es == st || es == en);
                set_marks(st, en, es);
            end
            tx_steady = (phase == 3);
            rx_steady = (phase == 3);
            base = words_in;
            while (words_in - base < 16)
            begin
                pick = $urandom_range(0, 99);
                len = ($urandom_range(0, 99) < 3) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 12);
                if (pick < 65)
                begin
                    fill_body(len);
                    send_frame($urandom_range(0, 9) != 0, 1'b1);
                end
                else if (pick < 80)
                begin
                    repeat ($urandom_range(1, 6))
                        send_byte(8'($urandom_range(0, 255)));
                end
                else if (pick < 88)
                begin
                    // truncated frame, no end mark
                    fill_body(len);
                    send_frame(1'b1, 1'b0);
                end
                else
                begin
                    // unstuffed random content between marks
                    send_byte(mark_start);
                    repeat ($urandom_range(0, 8))
                        send_byte(8'($urandom_range(0, 255)));
                    send_byte(mark_end);
                end
            end
            wait_results_done();
        end
        tx_steady = 1'b0;
        rx_steady = 1'b0;
    endtask

    // main sequence
    initial
    begin
        rst_n     = 1'b0;
        cfg_we    = 1'b0;
        cfg_addr  = CFG_START;
        cfg_wdata = 8'h00;
        s_tvalid  = 1'b0;
        s_tdata   = 8'h00;
        rx_state  = RX_IDLE;
        frame_cnt = 0;
        frame_crc = 16'h0000;
        mark_start = START_RST;
        mark_end   = END_RST;
        mark_esc   = ESCAPE_RST;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_directed();
        test_marks();
        test_overflow();
        test_backpressure();
        test_random();
        wait_results_done();

        $display("sent %0d raw words, checked %0d result words", words_in, words_out);
        $display("frames closed good %0d, checksum errors %0d, overflow aborts %0d",
                 frames_good, frames_bad, frames_aborted);
        if (mismatches == 0 && expected_words.size() == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

`default_nettype wire
